@@ hdl/infix_to_postfix_converter_unit_defines.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the infix-to-postfix checker.
// ============================================================================
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset
`define ITP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp check failed: same-cycle implication");

// Next-cycle implication, off during reset
`define ITP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp check failed: next-cycle implication");

`endif

@@ hdl/itp_pkg.sv @@
// ============================================================================
// itp_pkg
// Types, codes and character helpers for the infix-to-postfix converter.
// ============================================================================
package itp_pkg;

    localparam int STACK_DEPTH_DEFAULT = 32;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } state_t;

    // What a multi-cycle word is doing to the stack
    typedef enum logic [1:0] {
        KIND_FLUSH,
        KIND_CLOSE,
        KIND_OP
    } kind_t;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_UNMATCHED,
        ERR_ILLEGAL,
        ERR_OVERFLOW
    } err_t;

    // Stacked operator codes
    localparam logic [2:0] OP_LPAREN = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;
    localparam logic [2:0] OP_MOD    = 3'd5;

    // ASCII characters
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_MOD    = 8'h25;
    localparam logic [7:0] CH_NUL    = 8'h00;

    function automatic logic is_operand(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD});
    endfunction

    function automatic logic [2:0] op_code_of(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            CH_ADD:  code = OP_ADD;
            CH_SUB:  code = OP_SUB;
            CH_MUL:  code = OP_MUL;
            CH_DIV:  code = OP_DIV;
            CH_MOD:  code = OP_MOD;
            default: code = OP_LPAREN;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] op_char_of(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            OP_LPAREN: c = CH_LPAREN;
            OP_ADD:    c = CH_ADD;
            OP_SUB:    c = CH_SUB;
            OP_MUL:    c = CH_MUL;
            OP_DIV:    c = CH_DIV;
            OP_MOD:    c = CH_MOD;
            default:   c = CH_NUL;
        endcase
        return c;
    endfunction

    // Multiplicative operators rank above additive ones
    function automatic logic op_prio(input logic [2:0] code);
        return (code >= OP_MUL);
    endfunction

endpackage

@@ hdl/infix_to_postfix_converter_unit.sv @@
// ============================================================================
// infix_to_postfix_converter_unit
// Shunting-yard converter: infix ASCII in, postfix ASCII out, one word each.
// ============================================================================
// Operands, '(' and illegal characters are handled in their accepting
// cycle, and any result sits in the output register from the next cycle.
// A flush after an error is also handled in its accepting cycle. A word
// that walks the operator stack (an operator, ')' or a flush) is accepted
// and then passes:
//   - a read state and a compare state for every operator popped (the
//     stack memory has a registered read);
//   - a read and a test of the entry that stops the walk, unless the
//     pops empty the stack;
//   - a finishing state for the push or the last result, which repeats
//     when an error result follows popped operators.
// An operator on an empty stack goes straight to the finishing state.
// Input is taken only while the sequencer is idle and the output register
// is empty or draining. A stalled sink holds a walk in place whenever its
// next result is ready. After reset the stack is empty and needs no
// clearing pass.
// ============================================================================
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tlast,   // flush
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [2:0] m_axis_tuser,   // [0] has_char, [2:1] error_code
    output logic       m_axis_tlast    // last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // Operator stack memory
    logic [2:0]    stack_mem [STACK_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [2:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [2:0]    rd_data_reg;

    // Control and working registers
    itp_pkg::state_t state_reg, state_next;
    itp_pkg::kind_t  kind_reg, kind_next;
    logic [2:0]      code_reg, code_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            hold_reg, hold_next;
    logic            found_reg, found_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [7:0]      pend_char_reg, pend_char_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_char_reg, out_char_next;
    logic            out_has_reg, out_has_next;
    itp_pkg::err_t   out_err_reg, out_err_next;
    logic            out_last_reg, out_last_next;

    logic            can_emit;
    logic            accept;
    logic            start_stack;
    logic            pop_cond;
    itp_pkg::err_t   fin_err;
    logic            fin_wait;

    // Emit request into the output register
    logic            emit;
    logic [7:0]      emit_char;
    logic            emit_has;
    itp_pkg::err_t   emit_err;
    logic            emit_last;

    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == itp_pkg::ST_IDLE) && can_emit;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Words that must walk the stack
    assign start_stack = accept && !hold_reg &&
        (s_axis_tlast || (s_axis_tdata == itp_pkg::CH_RPAREN) ||
         itp_pkg::is_operator(s_axis_tdata));

    // Top-of-stack pops while it is an operator of enough priority
    assign pop_cond = (rd_data_reg != itp_pkg::OP_LPAREN) &&
        ((kind_reg != itp_pkg::KIND_OP) ||
         (itp_pkg::op_prio(rd_data_reg) >= itp_pkg::op_prio(code_reg)));

    // Terminating error of a stack walk
    always_comb
    begin
        fin_err = itp_pkg::ERR_NONE;
        if (kind_reg == itp_pkg::KIND_CLOSE && !found_reg)
        begin
            fin_err = itp_pkg::ERR_UNMATCHED;
        end
        else if (kind_reg == itp_pkg::KIND_OP && count_reg == DEPTH_C)
        begin
            fin_err = itp_pkg::ERR_OVERFLOW;
        end
    end

    assign fin_wait = (pend_valid_reg || fin_err != itp_pkg::ERR_NONE) && !can_emit;

    // Read address: current top entry
    assign mem_raddr = (count_reg == '0) ? '0 : AW'(count_reg - 1'b1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itp_pkg::ST_IDLE:
            begin
                if (start_stack)
                begin
                    state_next = (count_reg != '0) ? itp_pkg::ST_READ : itp_pkg::ST_FINISH;
                end
            end
            itp_pkg::ST_READ:
            begin
                state_next = itp_pkg::ST_EVAL;
            end
            itp_pkg::ST_EVAL:
            begin
                if (!pop_cond)
                begin
                    state_next = itp_pkg::ST_FINISH;
                end
                else if (!pend_valid_reg || can_emit)
                begin
                    state_next = (count_reg != CW'(1)) ? itp_pkg::ST_READ
                                                       : itp_pkg::ST_FINISH;
                end
            end
            itp_pkg::ST_FINISH:
            begin
                if (!fin_wait && !(pend_valid_reg && fin_err != itp_pkg::ERR_NONE))
                begin
                    state_next = itp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itp_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        kind_next       = kind_reg;
        code_next       = code_reg;
        count_next      = count_reg;
        hold_next       = hold_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        emit            = 1'b0;
        emit_char       = itp_pkg::CH_NUL;
        emit_has        = 1'b0;
        emit_err        = itp_pkg::ERR_NONE;
        emit_last       = 1'b1;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = code_reg;

        case (state_reg)
            itp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    code_next       = itp_pkg::op_code_of(s_axis_tdata);
                    if (s_axis_tlast)
                    begin
                        kind_next = itp_pkg::KIND_FLUSH;
                        if (hold_reg)
                        begin
                            // abandoned expression: drop the stack silently
                            count_next = '0;
                            hold_next  = 1'b0;
                        end
                    end
                    else if (!hold_reg)
                    begin
                        if (s_axis_tdata == itp_pkg::CH_LPAREN)
                        begin
                            if (count_reg < DEPTH_C)
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = itp_pkg::OP_LPAREN;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                emit_err  = itp_pkg::ERR_OVERFLOW;
                                hold_next = 1'b1;
                            end
                        end
                        else if (s_axis_tdata == itp_pkg::CH_RPAREN)
                        begin
                            kind_next = itp_pkg::KIND_CLOSE;
                        end
                        else if (itp_pkg::is_operand(s_axis_tdata))
                        begin
                            emit      = 1'b1;
                            emit_char = s_axis_tdata;
                            emit_has  = 1'b1;
                        end
                        else if (itp_pkg::is_operator(s_axis_tdata))
                        begin
                            kind_next = itp_pkg::KIND_OP;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            emit_err  = itp_pkg::ERR_ILLEGAL;
                            hold_next = 1'b1;
                        end
                    end
                end
            end
            itp_pkg::ST_READ:
            begin
                // stack memory read in flight
            end
            itp_pkg::ST_EVAL:
            begin
                if (pop_cond)
                begin
                    if (!pend_valid_reg || can_emit)
                    begin
                        // previous pop is known not to be the last result
                        emit            = pend_valid_reg;
                        emit_char       = pend_char_reg;
                        emit_has        = 1'b1;
                        emit_last       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_char_next  = itp_pkg::op_char_of(rd_data_reg);
                        count_next      = count_reg - 1'b1;
                    end
                end
                else if (kind_reg == itp_pkg::KIND_CLOSE)
                begin
                    // matching '(' found: drop it
                    found_next = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            itp_pkg::ST_FINISH:
            begin
                if (!fin_wait)
                begin
                    if (pend_valid_reg)
                    begin
                        emit            = 1'b1;
                        emit_char       = pend_char_reg;
                        emit_has        = 1'b1;
                        emit_last       = (fin_err == itp_pkg::ERR_NONE);
                        pend_valid_next = 1'b0;
                    end
                    else if (fin_err != itp_pkg::ERR_NONE)
                    begin
                        emit      = 1'b1;
                        emit_err  = fin_err;
                        hold_next = 1'b1;
                    end

                    if (fin_err == itp_pkg::ERR_NONE)
                    begin
                        if (kind_reg == itp_pkg::KIND_FLUSH)
                        begin
                            count_next = '0;
                        end
                        else if (kind_reg == itp_pkg::KIND_OP)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register load and drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_has_next   = out_has_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_has_next   = emit_has;
            out_err_next   = emit_err;
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Stack memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= itp_pkg::ST_IDLE;
            count_reg      <= '0;
            hold_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hold_reg       <= hold_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        code_reg      <= code_next;
        found_reg     <= found_next;
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_has_reg   <= out_has_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tuser  = {out_err_reg, out_has_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ hdl/itp_checker.sv @@
// ============================================================================
// itp_checker
// Port-level checks for the infix-to-postfix converter, bound to the top.
// ============================================================================
`include "infix_to_postfix_converter_unit_defines.svh"

module itp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic has_char;
    logic err_word;

    // Result word flags from tuser
    assign has_char = m_axis_tuser[0];
    assign err_word = (m_axis_tuser[2:1] != itp_pkg::ERR_NONE);

    // A result word stays offered until taken
    `ITP_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Character words carry no error code
    `ITP_ASSERT_IMP(a_char_no_err, clk, rst_n, m_axis_tvalid && has_char, !err_word)

    // An error word always closes the results of its input
    `ITP_ASSERT_IMP(a_err_last, clk, rst_n, m_axis_tvalid && err_word, m_axis_tlast)

    // No new input while an input's results are still incomplete
    `ITP_ASSERT_IMP(a_no_overlap, clk, rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
